// File: sv/mscs_pkg.sv
package mscs_pkg;

  localparam int ValueBits = 16;
  localparam int CoordBits = 16;
  localparam int FracBits = 16;
  localparam int NumBits = ValueBits + 1;
  localparam int DivSteps = FracBits;
  localparam int MulBits = CoordBits + FracBits + 1;

  localparam logic [1:0] EDGE_BOTTOM = 2'd0;
  localparam logic [1:0] EDGE_RIGHT = 2'd1;
  localparam logic [1:0] EDGE_TOP = 2'd2;
  localparam logic [1:0] EDGE_LEFT = 2'd3;

  typedef struct packed {
    logic signed [ValueBits-1:0] corner_low_left;
    logic signed [ValueBits-1:0] corner_low_right;
    logic signed [ValueBits-1:0] corner_high_right;
    logic signed [ValueBits-1:0] corner_high_left;
    logic [CoordBits-1:0] x_left;
    logic [CoordBits-1:0] x_right;
    logic [CoordBits-1:0] y_bottom;
    logic [CoordBits-1:0] y_top;
  } cell_t;

  typedef struct packed {
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
    logic [1:0] start_edge;
    logic [1:0] end_edge;
    logic [3:0] case_code;
    logic last_segment;
  } segment_t;

  // one endpoint job: numerator, denominator, blend bounds, fixed coordinate
  typedef struct packed {
    logic [NumBits-1:0] num;
    logic [NumBits-1:0] den;
    logic [CoordBits-1:0] from;
    logic [CoordBits-1:0] to;
    logic [CoordBits-1:0] fixed;
    logic along_y;
  } edge_job_t;

  typedef struct packed {
    logic [1:0] edge_a;
    logic [1:0] edge_b;
    logic [3:0] case_code;
    logic last_segment;
  } seg_tag_t;

  function automatic logic [1:0] seg_count(input logic [3:0] code);
    logic [1:0] r;
    case (code)
      4'd0, 4'd15: r = 2'd0;
      4'd5, 4'd10: r = 2'd2;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // edges of segment s: {edge_a, edge_b}
  function automatic logic [3:0] seg_edges(input logic [3:0] code, input logic s);
    logic [3:0] r;
    case (code)
      4'd1: r = {EDGE_LEFT, EDGE_BOTTOM};
      4'd2: r = {EDGE_BOTTOM, EDGE_RIGHT};
      4'd3: r = {EDGE_LEFT, EDGE_RIGHT};
      4'd4: r = {EDGE_RIGHT, EDGE_TOP};
      4'd5: r = s ? {EDGE_RIGHT, EDGE_BOTTOM} : {EDGE_LEFT, EDGE_TOP};
      4'd6: r = {EDGE_BOTTOM, EDGE_TOP};
      4'd7: r = {EDGE_LEFT, EDGE_TOP};
      4'd8: r = {EDGE_TOP, EDGE_LEFT};
      4'd9: r = {EDGE_TOP, EDGE_BOTTOM};
      4'd10: r = s ? {EDGE_TOP, EDGE_RIGHT} : {EDGE_BOTTOM, EDGE_LEFT};
      4'd11: r = {EDGE_TOP, EDGE_RIGHT};
      4'd12: r = {EDGE_RIGHT, EDGE_LEFT};
      4'd13: r = {EDGE_RIGHT, EDGE_BOTTOM};
      4'd14: r = {EDGE_BOTTOM, EDGE_LEFT};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/mscs_endpoint.sv
module mscs_endpoint (
  input  logic clk,
  input  logic advance,
  input  mscs_pkg::edge_job_t job,
  output logic [mscs_pkg::CoordBits-1:0] px,
  output logic [mscs_pkg::CoordBits-1:0] py
);
  import mscs_pkg::*;

  localparam int RemBits = NumBits + 1;

  logic [RemBits-1:0] rem [DivSteps+1];
  logic [NumBits-1:0] den [DivSteps+1];
  logic [FracBits-1:0] quo [DivSteps+1];
  logic zero [DivSteps+1];
  logic [CoordBits-1:0] from [DivSteps+1];
  logic [CoordBits-1:0] to [DivSteps+1];
  logic [CoordBits-1:0] fixed [DivSteps+2];
  logic along_y [DivSteps+2];
  logic [MulBits-1:0] prod_a;
  logic [MulBits-1:0] prod_b;
  logic [FracBits-1:0] frac;
  logic [MulBits:0] sum;

  // stage 0: a quotient of one or more saturates, so start with num vs den
  always_ff @(posedge clk) begin
    if (advance) begin
      zero[0] <= (job.den == '0) || (job.num >= job.den);
      rem[0] <= {1'b0, job.num};
      den[0] <= job.den;
      quo[0] <= '0;
      from[0] <= job.from;
      to[0] <= job.to;
      fixed[0] <= job.fixed;
      along_y[0] <= job.along_y;
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [RemBits-1:0] shifted;
    logic ge;
    assign shifted = {rem[i][RemBits-2:0], 1'b0};
    assign ge = shifted >= {1'b0, den[i]};
    always_ff @(posedge clk) begin
      if (advance) begin
        rem[i+1] <= ge ? shifted - {1'b0, den[i]} : shifted;
        quo[i+1] <= {quo[i][FracBits-2:0], ge};
        den[i+1] <= den[i];
        zero[i+1] <= zero[i];
        from[i+1] <= from[i];
        to[i+1] <= to[i];
        fixed[i+1] <= fixed[i];
        along_y[i+1] <= along_y[i];
      end
    end
  end

  // num >= den saturates; den zero never reaches a selected edge
  assign frac = zero[DivSteps] ? (den[DivSteps] == '0 ? '0 : '1) : quo[DivSteps];

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_a <= MulBits'(({1'b1, {FracBits{1'b0}}}) - {1'b0, frac})
                * MulBits'(from[DivSteps]);
      prod_b <= MulBits'(frac) * MulBits'(to[DivSteps]);
      fixed[DivSteps+1] <= fixed[DivSteps];
      along_y[DivSteps+1] <= along_y[DivSteps];
    end
  end

  assign sum = {1'b0, prod_a} + {1'b0, prod_b};

  always_ff @(posedge clk) begin
    if (advance) begin
      if (along_y[DivSteps+1]) begin
        px <= fixed[DivSteps+1];
        py <= sum[FracBits +: CoordBits];
      end else begin
        px <= sum[FracBits +: CoordBits];
        py <= fixed[DivSteps+1];
      end
    end
  end

endmodule

// File: sv/marching_squares_cell_segments.sv
// Cell register, then endpoint entry stage, divider, product and output registers.
// One cell or segment per cycle unless stalled; a saddle cell yields two segments.
// The divider is a pipeline of one restoring step per stage.
// Reset: synchronous, clears all valid bits and sets iso_level to zero.
module marching_squares_cell_segments (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic signed [mscs_pkg::ValueBits-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  mscs_pkg::cell_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output mscs_pkg::segment_t out_data
);
  import mscs_pkg::*;

  localparam int Depth = DivSteps + 3;

  logic signed [ValueBits-1:0] iso_level;
  cell_t cur_cell;
  logic cell_valid;
  logic [3:0] code;
  logic second;
  logic [1:0] count;
  logic [3:0] edges;
  logic issue;
  logic cell_done;
  logic advance;
  logic [Depth-1:0] pipe_valid;
  seg_tag_t tag [Depth];
  edge_job_t job_a;
  edge_job_t job_b;
  logic [CoordBits-1:0] ax, ay, bx, by;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level <= '0;
    end else if (cfg_valid) begin
      iso_level <= cfg_data;
    end
  end

  assign advance = !out_valid || out_ready;

  always_comb begin
    code[0] = cur_cell.corner_low_left < iso_level;
    code[1] = cur_cell.corner_low_right < iso_level;
    code[2] = cur_cell.corner_high_right < iso_level;
    code[3] = cur_cell.corner_high_left < iso_level;
  end

  assign count = seg_count(code);
  assign edges = seg_edges(code, second);
  assign issue = cell_valid && (count != 2'd0);
  assign cell_done = !cell_valid || count != 2'd2 || second;
  assign in_ready = advance && cell_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
      second <= 1'b0;
    end else if (advance) begin
      if (cell_done) begin
        cell_valid <= in_valid;
        second <= 1'b0;
      end else begin
        second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cur_cell <= in_data;
    end
  end

  function automatic edge_job_t make_job(input logic [1:0] e, input cell_t c,
                                         input logic signed [ValueBits-1:0] iso);
    edge_job_t j;
    logic signed [NumBits-1:0] b, o, n, d;
    b = '0;
    o = '0;
    j.from = '0;
    j.to = '0;
    j.fixed = '0;
    j.along_y = 1'b0;
    case (e)
      EDGE_BOTTOM: begin
        b = NumBits'(c.corner_low_right);
        o = NumBits'(c.corner_low_left);
        j.from = c.x_right;
        j.to = c.x_left;
        j.fixed = c.y_bottom;
      end
      EDGE_RIGHT: begin
        b = NumBits'(c.corner_high_right);
        o = NumBits'(c.corner_low_right);
        j.from = c.y_top;
        j.to = c.y_bottom;
        j.fixed = c.x_right;
        j.along_y = 1'b1;
      end
      EDGE_TOP: begin
        b = NumBits'(c.corner_high_left);
        o = NumBits'(c.corner_high_right);
        j.from = c.x_left;
        j.to = c.x_right;
        j.fixed = c.y_top;
      end
      default: begin
        b = NumBits'(c.corner_low_left);
        o = NumBits'(c.corner_high_left);
        j.from = c.y_bottom;
        j.to = c.y_top;
        j.fixed = c.x_left;
        j.along_y = 1'b1;
      end
    endcase
    n = NumBits'(iso) - b;
    d = o - b;
    j.num = n[NumBits-1] ? -n : n;
    j.den = d[NumBits-1] ? -d : d;
    return j;
  endfunction

  assign job_a = make_job(edges[3:2], cur_cell, iso_level);
  assign job_b = make_job(edges[1:0], cur_cell, iso_level);

  mscs_endpoint u_ep_a (
    .clk(clk), .advance(advance),
    .job(job_a), .px(ax), .py(ay)
  );

  mscs_endpoint u_ep_b (
    .clk(clk), .advance(advance),
    .job(job_b), .px(bx), .py(by)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else if (advance) begin
      pipe_valid <= {pipe_valid[Depth-2:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag[0] <= '{edge_a: edges[3:2], edge_b: edges[1:0], case_code: code,
                  last_segment: (count != 2'd2) || second};
    end
  end

  for (genvar i = 1; i < Depth; i++) begin : g_tag
    always_ff @(posedge clk) begin
      if (advance) begin
        tag[i] <= tag[i-1];
      end
    end
  end

  assign out_valid = pipe_valid[Depth-1];

  always_comb begin
    out_data.start_x = ax;
    out_data.start_y = ay;
    out_data.end_x = bx;
    out_data.end_y = by;
    out_data.start_edge = tag[Depth-1].edge_a;
    out_data.end_edge = tag[Depth-1].edge_b;
    out_data.case_code = tag[Depth-1].case_code;
    out_data.last_segment = tag[Depth-1].last_segment;
  end

endmodule
